// ----- hdl/pvsa_pkg.sv -----
`default_nettype none
package pvsa_pkg;

	// Input item kinds carried on s_tuser
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// Allocation counter saturates here
	localparam logic [6:0] COUNT_CAP = 7'd64;

	// Starting weakest values sit above anything a slot can hold
	localparam logic [3:0]  PRI_TOP  = 4'd8;
	localparam logic [16:0] GAIN_TOP = 17'h10000;

	typedef struct packed {
		logic [15:0] loops;
		logic [31:0] used;
		logic [15:0] gain;
		logic [2:0]  pri;
		logic        looping;
		logic        playing;
		logic        active;
		logic        locked;
	} slot_rec_t;

	typedef struct packed {
		logic [3:0]  pri;
		logic [16:0] gain;
		logic [31:0] used;
		logic [15:0] loops;
		logic        all_playing;
		logic        have_weak;
	} weak_t;

	typedef struct packed {
		logic  empty;
		logic  take;
		weak_t next;
	} judge_t;

endpackage
`default_nettype wire

// ----- hdl/pvsa_slot_ram.sv -----
`default_nettype none
module pvsa_slot_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   we,
	input  wire [AW-1:0]          waddr,
	input  pvsa_pkg::slot_rec_t   wdata,
	input  wire [AW-1:0]          raddr,
	output pvsa_pkg::slot_rec_t   rdata
);
	import pvsa_pkg::*;

	slot_rec_t        mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	slot_rec_t        rd_data_q;
	logic             rd_ok_q;

	// Storage itself holds no reset; the valid bits stand in for it
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_ok_q <= valid_q[raddr];
		end
	end

	// An entry never written reads as all zero
	assign rdata = rd_ok_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// ----- hdl/pvsa_judge.sv -----
`default_nettype none
module pvsa_judge (
	input  pvsa_pkg::slot_rec_t rec,
	input  pvsa_pkg::weak_t     weakest,
	input  wire [2:0]           pri_req,
	output pvsa_pkg::judge_t    res
);
	import pvsa_pkg::*;

	logic pri_lower;
	logic gain_lower;
	logic time_lower;
	logic more_loops;

	assign pri_lower  = {1'b0, rec.pri} < weakest.pri;
	assign gain_lower = {1'b0, rec.gain} < weakest.gain;
	assign time_lower = rec.used < weakest.used;
	assign more_loops = rec.loops > weakest.loops;

	always_comb begin
		res.empty = 1'b0;
		res.take  = 1'b0;
		res.next  = weakest;
		if (!rec.locked) begin
			if (!rec.active) begin
				res.empty = 1'b1;
			end else if (rec.playing) begin
				// playing slot: lower priority, or quieter or older if not looping
				res.take = weakest.all_playing && (rec.pri < pri_req) &&
					(pri_lower || (!rec.looping && (gain_lower || time_lower)));
				if (res.take) begin
					res.next.pri       = {1'b0, rec.pri};
					res.next.used      = rec.used;
					res.next.gain      = {1'b0, rec.gain};
					res.next.have_weak = 1'b1;
				end
			end else begin
				// idle slot: once seen, playing slots are no longer taken
				res.next.all_playing = 1'b0;
				res.take = !weakest.have_weak || more_loops || pri_lower || time_lower;
				if (res.take) begin
					res.next.pri       = {1'b0, rec.pri};
					res.next.used      = rec.used;
					res.next.loops     = rec.loops;
					res.next.have_weak = 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/priority_voice_slot_allocator_unit.sv -----
`default_nettype none
// Voice slot allocator. A table of MAX_SLOTS voice slots is kept in a single-port-write,
// registered-read memory. A write beat (s_tuser = 1) stores every attribute of one slot
// and goes straight to its result. An allocate beat (s_tuser = 0) scans
// slots 0 .. min(sources_in_use, MAX_SLOTS)-1 one per cycle through the slot memory and
// one shared compare unit: the first unlocked inactive slot is taken at once, otherwise
// the weakest candidate under the voice-stealing rules is chosen. The chosen slot is
// cleared and marked active, and the allocation count (saturating at 64) advances. An
// allocate beat stops its scan early when a free slot turns up, and the memory read port,
// one slot a cycle, paces the scan.
// One beat is worked on at a time: s_tready is low from acceptance until the result has
// been placed in the output register. Each beat gives exactly one result beat. After
// reset every slot reads as all zero, and sources_in_use is 64; write the register only
// while the block is idle.
module priority_voice_slot_allocator_unit #(
	parameter int MAX_SLOTS = 64
) (
	input  wire          clk,
	input  wire          arst_n,
	// configuration: sources_in_use
	input  wire          cfg_wr_en,
	input  wire  [6:0]   cfg_wr_data,
	// input stream
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire          s_tuser,  // mode
	// s_tdata, low bit up: slot_index[5:0], priority_req[8:6], locked[9], active[10],
	// playing[11], looping[12], gain[28:13], used_time[60:29], loop_count[76:61],
	// now_ms[108:77], zero fill[111:109]
	input  wire  [111:0] s_tdata,
	// result stream
	output logic         m_tvalid,
	input  wire          m_tready,
	// m_tdata, low bit up: granted[0], slot[6:1], allocation count[13:7], zero fill[15:14]
	output logic [15:0]  m_tdata
);
	import pvsa_pkg::*;

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int PW = $clog2(MAX_SLOTS + 1);
	localparam logic [8:0] MAX_EXT = 9'(MAX_SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t     state_q;
	logic [6:0] sources_q;
	logic [6:0] count_q;

	// Unpack the input beat
	logic [5:0]  in_slot_index;
	logic [2:0]  in_priority_req;
	slot_rec_t   in_rec;
	logic [31:0] in_now_ms;

	assign in_slot_index   = s_tdata[5:0];
	assign in_priority_req = s_tdata[8:6];
	assign in_rec.locked   = s_tdata[9];
	assign in_rec.active   = s_tdata[10];
	assign in_rec.playing  = s_tdata[11];
	assign in_rec.looping  = s_tdata[12];
	assign in_rec.pri      = s_tdata[8:6];
	assign in_rec.gain     = s_tdata[28:13];
	assign in_rec.used     = s_tdata[60:29];
	assign in_rec.loops    = s_tdata[76:61];
	assign in_now_ms       = s_tdata[108:77];

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Scan length, clipped to the table
	logic [8:0] cfg_ext;
	logic [8:0] n_sel;
	assign cfg_ext = 9'(sources_q);
	assign n_sel   = (cfg_ext > MAX_EXT) ? MAX_EXT : cfg_ext;

	logic in_range;
	assign in_range = 9'(in_slot_index) < MAX_EXT;

	// Scan state
	logic [PW-1:0] n_q;
	logic [PW-1:0] ptr_q;
	logic [2:0]    pri_q;
	weak_t         weak_q;
	logic [IW-1:0] weak_idx_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          hit_q;
	logic [IW-1:0] chosen_q;

	logic issue;
	logic eval;
	assign issue = (state_q == ST_SCAN) && (ptr_q < n_q);
	assign eval  = (state_q == ST_SCAN) && rd_vld_s1;

	// Slot memory
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	slot_rec_t     mem_wdata;
	slot_rec_t     mem_rdata;
	slot_rec_t     fresh_rec;

	// Freshly allocated slot: everything cleared, then marked active
	always_comb begin
		fresh_rec        = '0;
		fresh_rec.active = 1'b1;
	end

	always_comb begin
		if (state_q == ST_COMMIT) begin
			mem_we    = hit_q;
			mem_waddr = chosen_q;
			mem_wdata = fresh_rec;
		end else begin
			mem_we    = accept && (s_tuser == MODE_WRITE) && in_range;
			mem_waddr = IW'(in_slot_index);
			mem_wdata = in_rec;
		end
	end

	pvsa_slot_ram #(
		.DEPTH(MAX_SLOTS),
		.AW   (IW)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (ptr_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	// Shared compare unit, one slot a cycle
	judge_t judge;

	pvsa_judge u_judge (
		.rec    (mem_rdata),
		.weakest(weak_q),
		.pri_req(pri_q),
		.res    (judge)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sources_q <= 7'd64;
		end else if (cfg_wr_en) begin
			sources_q <= cfg_wr_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded below
			if (m_tvalid && m_tready && (state_q != ST_RESULT)) begin
				m_tvalid <= 1'b0;
			end
			rd_vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q <= 1'b0;
						if (s_tuser == MODE_WRITE) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (eval && judge.empty) begin
						// free slot: take it at once
						hit_q   <= 1'b1;
						state_q <= ST_COMMIT;
					end else if (!issue && !rd_vld_s1) begin
						// whole range seen: fall back to the weakest candidate
						hit_q   <= weak_q.have_weak;
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (hit_q && (count_q < COUNT_CAP)) begin
						count_q <= count_q + 7'd1;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan datapath
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q[IW-1:0];
		if (issue) begin
			ptr_q <= ptr_q + PW'(1);
		end
		case (state_q)
			ST_IDLE: begin
				ptr_q              <= '0;
				n_q                <= PW'(n_sel);
				pri_q              <= in_priority_req;
				weak_q.pri         <= PRI_TOP;
				weak_q.gain        <= GAIN_TOP;
				weak_q.used        <= in_now_ms;
				weak_q.loops       <= '0;
				weak_q.all_playing <= 1'b1;
				weak_q.have_weak   <= 1'b0;
				weak_idx_q         <= '0;
			end
			ST_SCAN: begin
				if (eval && judge.empty) begin
					chosen_q <= rd_idx_s1;
				end else if (eval) begin
					weak_q <= judge.next;
					if (judge.take) begin
						weak_idx_q <= rd_idx_s1;
					end
				end else if (!issue) begin
					chosen_q <= weak_idx_q;
				end
			end
			ST_RESULT: begin
				if (!m_tvalid || m_tready) begin
					m_tdata[0]     <= hit_q;
					m_tdata[6:1]   <= hit_q ? 6'(chosen_q) : 6'd0;
					m_tdata[13:7]  <= count_q;
					m_tdata[15:14] <= 2'b00;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
